[src/backend_server_selector_unit_macros.svh]
// Assertion macros used by the selector checker file.
`ifndef BACKEND_SERVER_SELECTOR_UNIT_MACROS_SVH
`define BACKEND_SERVER_SELECTOR_UNIT_MACROS_SVH
// An implication checked at every clock edge outside reset.
`define BSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// An implication whose consequent is checked in the cycle after its antecedent.
`define BSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[src/bss_pkg.sv]
// ----------------------------------------------------------------------------
// Backend server selector package
// Payload types, commands and codes shared by the selector modules.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam logic [2:0] ACT_SELECT  = 3'd0;
	localparam logic [2:0] ACT_RELEASE = 3'd1;
	localparam logic [2:0] ACT_FAIL    = 3'd2;
	localparam logic [2:0] ACT_DISABLE = 3'd3;
	localparam logic [2:0] ACT_ENABLE  = 3'd4;
	localparam logic [2:0] ACT_TIMES   = 3'd5;

	localparam logic [2:0] MODE_MS = 3'd0;
	localparam logic [2:0] MODE_RR = 3'd1;
	localparam logic [2:0] MODE_LC = 3'd2;
	localparam logic [2:0] MODE_RT = 3'd3;
	localparam logic [2:0] MODE_RD = 3'd4;
	localparam logic [2:0] MODE_HS = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_BADMODE = 2'd2;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_ACTIVE  = 2'd1;
	localparam logic [1:0] REG_DEFTIME = 2'd2;

	localparam logic [31:0] FAIL_HOLD_RESET = 32'd60;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] now_time;
		logic [3:0]  slot;
		logic [31:0] disable_duration;
		logic [4:0]  random_step;
		logic [3:0]  random_pick;
		logic [31:0] hash_value;
		logic [31:0] response_time;
		logic [31:0] wait_time;
	} in_item_t;

	typedef struct packed {
		logic [3:0] chosen_slot;
		logic [3:0] chosen_server_id;
		logic [1:0] status;
	} out_item_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;       // capture input item, do slot action, start modulo unit
		logic mod_step;   // one restoring step of the modulo unit
		logic walk_init;  // start walk from prepared pointer
		logic walk_step;  // examine one slot
		logic finish;     // commit selection, build result
		logic finish_na;  // non-select result
	} ctl_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic walk_done;
	} ctl_sts_t;

endpackage

[src/bss_ctrl.sv]
// ----------------------------------------------------------------------------
// Selector controller
// Sequences slot action, modulo reduction, slot walk and result hand-off.
// ----------------------------------------------------------------------------
module bss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        in_action,
	output logic              out_valid,
	input  logic              out_ready,
	output bss_pkg::ctl_cmd_t cmd,
	input  bss_pkg::ctl_sts_t sts
);
	typedef enum logic [2:0] {S_IDLE, S_MOD, S_WINIT, S_WALK, S_FIN, S_OUT} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		cmd = '0;
		cmd.load      = in_valid && in_ready;
		cmd.mod_step  = (state_q == S_MOD);
		cmd.walk_init = (state_q == S_WINIT);
		cmd.walk_step = (state_q == S_WALK);
		cmd.finish    = (state_q == S_FIN);
		cmd.finish_na = in_valid && in_ready && (in_action != bss_pkg::ACT_SELECT)
			&& (in_action != bss_pkg::ACT_FAIL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						if (cmd.finish_na)
							out_valid <= 1'b1;
						else
							state_q <= S_MOD;
					end
				end
				S_MOD:   if (sts.mod_done) state_q <= S_WINIT;
				S_WINIT: state_q <= S_WALK;
				S_WALK:  if (sts.walk_done) state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[src/bss_datapath.sv]
// ----------------------------------------------------------------------------
// Selector datapath
// Slot table, modulo unit and walk registers for the server selector.
// ----------------------------------------------------------------------------
module bss_datapath #(
	parameter int MAX_SERVERS = 16,
	parameter int TIME_BITS   = 32,
	parameter int COUNT_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  bss_pkg::in_item_t  item,
	input  bss_pkg::ctl_cmd_t  cmd,
	output bss_pkg::ctl_sts_t  sts,
	output bss_pkg::out_item_t result
);
	localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int NW = $clog2(MAX_SERVERS + 1);
	localparam int MB = 32;

	logic [2:0]            mode_q;
	logic [4:0]            active_q;
	logic [31:0]           deftime_q;
	logic [MAX_SERVERS-1:0] dis_q;
	logic [TIME_BITS-1:0]  reen_q [MAX_SERVERS];
	logic [COUNT_BITS-1:0] conn_q [MAX_SERVERS];
	logic [31:0]           rtt_q  [MAX_SERVERS];
	logic [31:0]           wtt_q  [MAX_SERVERS];
	logic [3:0]            id_q   [MAX_SERVERS];
	logic [SW-1:0]         rot_q;

	bss_pkg::in_item_t     it_q;
	logic [NW-1:0]         n_q;
	// Modulo unit: three reductions run in sequence over one shift-subtract.
	logic [1:0]            mphase_q;
	logic [5:0]            mcnt_q;
	logic [MB:0]           rem_q;
	logic [MB-1:0]         dvd_q;
	logic [SW-1:0]         ptr_mod_q, hash_mod_q, pick_mod_q;
	// Walk.
	logic [SW-1:0]         p_q, best_q, start_q;
	logic [NW-1:0]         k_q;
	logic                  found_q, firsthit_q;
	logic [31:0]           bestgap_q;
	logic [COUNT_BITS-1:0] bestconn_q;

	logic [NW-1:0] n_eff;
	always_comb begin
		if (active_q == 5'd0) n_eff = NW'(1);
		else if (32'(active_q) > 32'(MAX_SERVERS)) n_eff = NW'(MAX_SERVERS);
		else n_eff = NW'(active_q);
	end

	function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] v, input logic [NW-1:0] n);
		logic [NW:0] t;
		t = (NW+1)'(v) + 1'b1;
		if (t >= (NW+1)'(n)) t = '0;
		return SW'(t);
	endfunction

	logic [SW-1:0] isidx;
	assign isidx = SW'(item.slot);
	logic isok;
	assign isok = (32'(item.slot) < 32'(MAX_SERVERS));

	// Restoring divide step.
	logic [MB:0] trial;
	always_comb trial = {rem_q[MB-1:0], dvd_q[MB-1]} - (MB+1)'(n_q);
	logic [MB:0] next_rem;
	assign next_rem = trial[MB] ? {rem_q[MB-1:0], dvd_q[MB-1]} : trial;

	logic [SW-1:0] cur_p;
	assign cur_p = p_q;
	logic healthy;
	logic [TIME_BITS-1:0] now_t;
	assign now_t = TIME_BITS'(it_q.now_time);
	always_comb begin
		if (!dis_q[cur_p]) healthy = 1'b1;
		else if (mode_q == bss_pkg::MODE_MS) healthy = now_t > reen_q[cur_p];
		else healthy = now_t >= reen_q[cur_p];
	end
	logic [31:0] cur_gap;
	assign cur_gap = (rtt_q[cur_p] > wtt_q[cur_p]) ? rtt_q[cur_p] - wtt_q[cur_p]
		: wtt_q[cur_p] - rtt_q[cur_p];

	logic [NW:0] rsum;
	assign rsum = (NW+1)'(ptr_mod_q) + (NW+1)'(pick_mod_q);

	assign sts.mod_done  = (mphase_q == 2'd3);
	assign sts.walk_done = (k_q == n_q) || (found_q && ((mode_q == bss_pkg::MODE_MS)
		|| (mode_q == bss_pkg::MODE_RR) || (mode_q == bss_pkg::MODE_RD)))
		|| (mode_q == bss_pkg::MODE_HS) || (mode_q > bss_pkg::MODE_HS);

	logic [SW-1:0] q_pick;
	assign q_pick = hash_mod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bss_pkg::MODE_RR;
			active_q <= 5'd1;
			deftime_q <= bss_pkg::FAIL_HOLD_RESET;
			dis_q <= '0;
			rot_q <= '0;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				reen_q[i] <= '0;
				conn_q[i] <= '0;
				rtt_q[i] <= '0;
				wtt_q[i] <= '0;
				id_q[i] <= 4'(i);
			end
			mphase_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bss_pkg::REG_MODE:    mode_q <= cfg_data[2:0];
					bss_pkg::REG_ACTIVE:  active_q <= cfg_data[4:0];
					bss_pkg::REG_DEFTIME: deftime_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				if (isok) begin
					case (item.action)
						bss_pkg::ACT_RELEASE:
							if (conn_q[isidx] != '0) conn_q[isidx] <= conn_q[isidx] - 1'b1;
						bss_pkg::ACT_FAIL: begin
							if (conn_q[isidx] != '0) conn_q[isidx] <= conn_q[isidx] - 1'b1;
							dis_q[isidx] <= 1'b1;
							reen_q[isidx] <= TIME_BITS'(item.now_time)
								+ TIME_BITS'(deftime_q);
						end
						bss_pkg::ACT_DISABLE: begin
							dis_q[isidx] <= 1'b1;
							reen_q[isidx] <= TIME_BITS'(item.now_time)
								+ TIME_BITS'(item.disable_duration);
						end
						bss_pkg::ACT_ENABLE: dis_q[isidx] <= 1'b0;
						bss_pkg::ACT_TIMES: begin
							rtt_q[isidx] <= item.response_time;
							wtt_q[isidx] <= item.wait_time;
						end
						default: ;
					endcase
				end
				mphase_q <= 2'd0;
				mcnt_q <= '0;
				rem_q <= '0;
				dvd_q <= 32'(rot_q);
			end
			if (cmd.mod_step && mphase_q != 2'd3) begin
				if (mcnt_q == 6'd31) begin
					mcnt_q <= '0;
					rem_q <= '0;
					case (mphase_q)
						2'd0: begin
							ptr_mod_q <= SW'(next_rem);
							dvd_q <= 32'(it_q.random_step);
						end
						2'd1: begin
							pick_mod_q <= SW'(next_rem);
							dvd_q <= (mode_q == bss_pkg::MODE_HS) ? it_q.hash_value
								: 32'(it_q.random_pick);
						end
						default:
							hash_mod_q <= SW'(next_rem);
					endcase
					mphase_q <= mphase_q + 1'b1;
				end else begin
					rem_q <= next_rem;
					dvd_q <= {dvd_q[MB-2:0], 1'b0};
					mcnt_q <= mcnt_q + 1'b1;
				end
			end
			if (cmd.walk_init) begin
				k_q <= '0;
				found_q <= 1'b0;
				firsthit_q <= 1'b0;
				if (mode_q == bss_pkg::MODE_RD) begin
					start_q <= SW'((rsum >= (NW+1)'(n_q)) ? rsum - (NW+1)'(n_q) : rsum);
					p_q <= SW'((rsum >= (NW+1)'(n_q)) ? rsum - (NW+1)'(n_q) : rsum);
					rot_q <= SW'((rsum >= (NW+1)'(n_q)) ? rsum - (NW+1)'(n_q) : rsum);
				end else if (mode_q == bss_pkg::MODE_HS) begin
					p_q <= hash_mod_q;
					start_q <= ptr_mod_q;
					rot_q <= ptr_mod_q;
				end else if (mode_q <= bss_pkg::MODE_HS) begin
					p_q <= ptr_mod_q;
					start_q <= ptr_mod_q;
					rot_q <= ptr_mod_q;
				end
			end
			if (cmd.walk_step) begin
				if (mode_q == bss_pkg::MODE_HS) begin
					found_q <= healthy;
					best_q <= p_q;
				end else if (mode_q <= bss_pkg::MODE_HS && k_q != n_q && !(found_q &&
						mode_q != bss_pkg::MODE_LC && mode_q != bss_pkg::MODE_RT)) begin
					if (healthy) begin
						if (mode_q == bss_pkg::MODE_LC) begin
							if (!found_q || conn_q[cur_p] < bestconn_q) begin
								found_q <= 1'b1;
								best_q <= cur_p;
								bestconn_q <= conn_q[cur_p];
							end
						end else if (mode_q == bss_pkg::MODE_RT) begin
							if (!found_q || cur_gap < bestgap_q) begin
								found_q <= 1'b1;
								best_q <= cur_p;
								bestgap_q <= cur_gap;
							end
						end else begin
							found_q <= 1'b1;
							best_q <= cur_p;
							firsthit_q <= (k_q == '0);
						end
					end
					p_q <= wrap_inc(p_q, n_q);
					k_q <= k_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				if (mode_q > bss_pkg::MODE_HS) begin
					result <= '{4'd0, 4'd0, bss_pkg::ST_BADMODE};
				end else if (!found_q) begin
					result <= '{4'd0, 4'd0, bss_pkg::ST_NONE};
				end else begin
					case (mode_q)
						bss_pkg::MODE_MS: rot_q <= best_q;
						bss_pkg::MODE_RR: rot_q <= wrap_inc(best_q, n_q);
						bss_pkg::MODE_LC, bss_pkg::MODE_RT: rot_q <= wrap_inc(start_q, n_q);
						bss_pkg::MODE_RD: rot_q <= best_q;
						default: ;
					endcase
					if (mode_q == bss_pkg::MODE_RD && !firsthit_q) begin
						result <= '{4'(q_pick), id_q[best_q], bss_pkg::ST_OK};
						if (q_pick != best_q) begin
							dis_q[best_q] <= dis_q[q_pick];
							dis_q[q_pick] <= dis_q[best_q];
							reen_q[best_q] <= reen_q[q_pick];
							reen_q[q_pick] <= reen_q[best_q];
							rtt_q[best_q] <= rtt_q[q_pick];
							rtt_q[q_pick] <= rtt_q[best_q];
							wtt_q[best_q] <= wtt_q[q_pick];
							wtt_q[q_pick] <= wtt_q[best_q];
							id_q[best_q] <= id_q[q_pick];
							id_q[q_pick] <= id_q[best_q];
							conn_q[best_q] <= conn_q[q_pick];
							conn_q[q_pick] <= (conn_q[best_q] != '1) ? conn_q[best_q] + 1'b1
								: conn_q[best_q];
						end else if (conn_q[q_pick] != '1) begin
							conn_q[q_pick] <= conn_q[q_pick] + 1'b1;
						end
					end else begin
						result <= '{4'(best_q), id_q[best_q], bss_pkg::ST_OK};
						if (conn_q[best_q] != '1) conn_q[best_q] <= conn_q[best_q] + 1'b1;
					end
				end
			end
			if (cmd.finish_na) result <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= item;
			n_q <= n_eff;
		end
	end
endmodule

[src/backend_server_selector_unit.sv]
// Non-select actions register their result straight from idle; select and connect-failed
// run the shared bit-serial modulo reductions, walk up to MAX_SERVERS slots and finish.
// One item at a time; a new item waits until the previous result has been taken.
// Reset: asynchronous, active low; configuration registers and slot table return to defaults.
// ----------------------------------------------------------------------------
// Backend server selector unit
// Picks a backend slot per connection under six balance modes.
// ----------------------------------------------------------------------------
module backend_server_selector_unit #(
	parameter int MAX_SERVERS = 16,
	parameter int TIME_BITS   = 32,
	parameter int COUNT_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bss_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bss_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	bss_pkg::ctl_cmd_t cmd;
	bss_pkg::ctl_sts_t sts;

	assign cfg_ready = 1'b1;

	bss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_action(in_data.action), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	bss_datapath #(.MAX_SERVERS(MAX_SERVERS), .TIME_BITS(TIME_BITS),
		.COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .item(in_data), .cmd(cmd), .sts(sts), .result(out_data)
	);
endmodule

[src/bss_checker.sv]
// ----------------------------------------------------------------------------
// Selector port checker
// Watches the input and output handshakes and the result fields of the selector.
// ----------------------------------------------------------------------------
`include "backend_server_selector_unit_macros.svh"
module bss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input bss_pkg::out_item_t out_data
);
	`BSS_ASSERT_IMPL(a_no_accept_while_full, clk, arst_n, out_valid, !in_ready)
	`BSS_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data))
	`BSS_ASSERT_IMPL(a_status_range, clk, arst_n, out_valid,
		out_data.status <= bss_pkg::ST_BADMODE)
	`BSS_ASSERT_IMPL(a_fail_zero, clk, arst_n, out_valid && out_data.status != bss_pkg::ST_OK,
		out_data.chosen_slot == 4'd0)
endmodule

bind backend_server_selector_unit bss_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[bench/backend_server_selector_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Backend server selector unit testbench
// Drives connection actions through the valid/ready input channel and
// checks every result against a local copy of the slot table and selection
// rules or a fixed value. A directed walk covers extremes and error paths;
// random traffic then runs with several register, idle and stall settings.
// ----------------------------------------------------------------------------
module backend_server_selector_unit_tb;

	localparam logic [2:0] ACT_SPARE_LO  = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI  = 3'd7;
	localparam logic [2:0] MODE_BAD_LO   = 3'd6;
	localparam logic [2:0] MODE_BAD_HI   = 3'd7;
	localparam int         SLOTS         = 16;
	localparam int         DRAIN_CYCLES  = 150;
	localparam int         RANDOM_ITEMS  = 740;
	localparam int         SEGMENTS      = 8;

	typedef struct {
		bit          dis;
		logic [31:0] reen;
		logic [15:0] conn;
		logic [31:0] rtt;
		logic [31:0] wtt;
		logic [3:0]  sid;
	} slot_rec_t;

	typedef struct {
		bit                 is_cfg;
		logic [1:0]         idx;
		logic [31:0]        val;
		bss_pkg::in_item_t  item;
		bit                 typed;
		bss_pkg::out_item_t res;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	bss_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	bss_pkg::out_item_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	slot_rec_t   slot_tab[SLOTS];
	logic [3:0]  rot_ptr;
	logic [2:0]  bal_mode;
	logic [4:0]  act_servers;
	logic [31:0] fail_hold;

	bss_pkg::out_item_t pending_results[$];
	row_t        plan[$];
	int          errors = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          picks_ok = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	logic [31:0] tnow = '0;

	backend_server_selector_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int slots_in_use();
		if (act_servers == 0)
			return 1;
		if (act_servers > SLOTS)
			return SLOTS;
		return act_servers;
	endfunction

	function automatic bit is_up(int i, logic [31:0] t, bit strict);
		if (!slot_tab[i].dis)
			return 1'b1;
		return strict ? (t > slot_tab[i].reen) : (t >= slot_tab[i].reen);
	endfunction

	function automatic logic [31:0] resp_gap(int i);
		return (slot_tab[i].rtt > slot_tab[i].wtt) ? slot_tab[i].rtt - slot_tab[i].wtt
			: slot_tab[i].wtt - slot_tab[i].rtt;
	endfunction

	function automatic logic [1:0] choose_slot(bss_pkg::in_item_t it, output int best);
		int n;
		int p;
		int q;
		bit found;
		bit better;
		slot_rec_t tmp;
		n = slots_in_use();
		best = 0;
		found = 1'b0;
		if (bal_mode > bss_pkg::MODE_HS)
			return bss_pkg::ST_BADMODE;
		rot_ptr = 4'(rot_ptr % n);
		p = rot_ptr;
		case (bal_mode)
			bss_pkg::MODE_MS, bss_pkg::MODE_RR: begin
				for (int k = 0; k < n && !found; k++) begin
					if (is_up(p, it.now_time, bal_mode == bss_pkg::MODE_MS)) begin
						found = 1'b1;
						best = p;
					end else
						p = (p + 1) % n;
				end
				if (found)
					rot_ptr = 4'((bal_mode == bss_pkg::MODE_MS) ? best : (best + 1) % n);
			end
			bss_pkg::MODE_LC, bss_pkg::MODE_RT: begin
				for (int k = 0; k < n; k++) begin
					if (is_up(p, it.now_time, 1'b0)) begin
						if (bal_mode == bss_pkg::MODE_LC)
							better = !found || slot_tab[p].conn < slot_tab[best].conn;
						else
							better = !found || resp_gap(p) < resp_gap(best);
						if (better) begin
							best = p;
							found = 1'b1;
						end
					end
					p = (p + 1) % n;
				end
				if (found)
					rot_ptr = 4'((rot_ptr + 1) % n);
			end
			bss_pkg::MODE_RD: begin
				p = (p + it.random_step) % n;
				rot_ptr = 4'(p);
				for (int k = 0; k < n && !found; k++) begin
					if (is_up(p, it.now_time, 1'b0)) begin
						found = 1'b1;
						if (k == 0)
							best = p;
						else begin
							q = it.random_pick % n;
							if (q != p) begin
								tmp = slot_tab[p];
								slot_tab[p] = slot_tab[q];
								slot_tab[q] = tmp;
							end
							best = q;
						end
						rot_ptr = 4'(p);
					end else
						p = (p + 1) % n;
				end
			end
			default: begin
				best = it.hash_value % n;
				found = is_up(best, it.now_time, 1'b0);
			end
		endcase
		if (!found)
			return bss_pkg::ST_NONE;
		if (slot_tab[best].conn != 16'hFFFF)
			slot_tab[best].conn++;
		return bss_pkg::ST_OK;
	endfunction

	function automatic bss_pkg::out_item_t apply_action(bss_pkg::in_item_t it);
		bss_pkg::out_item_t r;
		int best;
		int s;
		r = '0;
		s = it.slot;
		case (it.action)
			bss_pkg::ACT_SELECT, bss_pkg::ACT_FAIL: begin
				if (it.action == bss_pkg::ACT_FAIL) begin
					if (slot_tab[s].conn != 0)
						slot_tab[s].conn--;
					slot_tab[s].dis = 1'b1;
					slot_tab[s].reen = it.now_time + fail_hold;
				end
				r.status = choose_slot(it, best);
				if (r.status == bss_pkg::ST_OK) begin
					r.chosen_slot = 4'(best);
					r.chosen_server_id = slot_tab[best].sid;
				end
			end
			bss_pkg::ACT_RELEASE:
				if (slot_tab[s].conn != 0)
					slot_tab[s].conn--;
			bss_pkg::ACT_DISABLE: begin
				slot_tab[s].dis = 1'b1;
				slot_tab[s].reen = it.now_time + it.disable_duration;
			end
			bss_pkg::ACT_ENABLE:
				slot_tab[s].dis = 1'b0;
			bss_pkg::ACT_TIMES: begin
				slot_tab[s].rtt = it.response_time;
				slot_tab[s].wtt = it.wait_time;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		bss_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0)
				report("unexpected transfer", out_data.status, -1);
			else begin
				want = pending_results.pop_front();
				if (out_data.chosen_slot !== want.chosen_slot)
					report("chosen_slot", out_data.chosen_slot, want.chosen_slot);
				if (out_data.chosen_server_id !== want.chosen_server_id)
					report("chosen_server_id", out_data.chosen_server_id,
						want.chosen_server_id);
				if (out_data.status !== want.status)
					report("status", out_data.status, want.status);
			end
		end
	end

	task automatic send_item(bss_pkg::in_item_t it, bit typed, bss_pkg::out_item_t res);
		bss_pkg::out_item_t r;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		r = apply_action(it);
		if (r.status == bss_pkg::ST_OK && (it.action == bss_pkg::ACT_SELECT
				|| it.action == bss_pkg::ACT_FAIL))
			picks_ok++;
		pending_results.push_back(typed ? res : r);
		items_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			bss_pkg::REG_MODE:    bal_mode = val[2:0];
			bss_pkg::REG_ACTIVE:  act_servers = val[4:0];
			bss_pkg::REG_DEFTIME: fail_hold = val;
			default: ;
		endcase
	endtask

	function automatic bss_pkg::in_item_t mk(logic [2:0] a, logic [31:0] t, logic [31:0] s,
		logic [31:0] d, logic [31:0] st, logic [31:0] pk, logic [31:0] h,
		logic [31:0] rt, logic [31:0] wt);
		bss_pkg::in_item_t it;
		it.action = a;
		it.now_time = t;
		it.slot = s[3:0];
		it.disable_duration = d;
		it.random_step = st[4:0];
		it.random_pick = pk[3:0];
		it.hash_value = h;
		it.response_time = rt;
		it.wait_time = wt;
		return it;
	endfunction

	task automatic add_item(bss_pkg::in_item_t it, bit typed = 1'b0,
		bss_pkg::out_item_t res = '0);
		row_t r;
		r = '{1'b0, 2'd0, 32'd0, it, typed, res};
		plan.push_back(r);
	endtask

	task automatic add_cfg(logic [1:0] idx, logic [31:0] val);
		row_t r;
		r = '{1'b1, idx, val, '0, 1'b0, '0};
		plan.push_back(r);
	endtask

	function automatic bss_pkg::in_item_t rand_item();
		bss_pkg::in_item_t it;
		logic [191:0] raw;
		int roll;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(bss_pkg::in_item_t)-1:0];
		roll = $urandom_range(99);
		if (roll < 40)      it.action = bss_pkg::ACT_SELECT;
		else if (roll < 50) it.action = bss_pkg::ACT_RELEASE;
		else if (roll < 62) it.action = bss_pkg::ACT_FAIL;
		else if (roll < 74) it.action = bss_pkg::ACT_DISABLE;
		else if (roll < 84) it.action = bss_pkg::ACT_ENABLE;
		else if (roll < 96) it.action = bss_pkg::ACT_TIMES;
		else                it.action = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
		if ($urandom_range(99) < 3)
			tnow = $urandom;
		else
			tnow = tnow + $urandom_range(20);
		it.now_time = tnow;
		if ($urandom_range(99) < 90)
			it.slot = 4'($urandom_range(slots_in_use() - 1));
		if ($urandom_range(99) < 90)
			it.disable_duration = $urandom_range(100);
		if ($urandom_range(99) < 80) begin
			it.response_time = $urandom_range(1000);
			it.wait_time = $urandom_range(1000);
		end
		return it;
	endfunction

	initial begin
		automatic int per_seg = RANDOM_ITEMS / SEGMENTS;
		for (int i = 0; i < SLOTS; i++)
			slot_tab[i] = '{1'b0, 32'd0, 16'd0, 32'd0, 32'd0, i[3:0]};
		rot_ptr = '0;
		bal_mode = bss_pkg::MODE_RR;
		act_servers = 5'd1;
		fail_hold = bss_pkg::FAIL_HOLD_RESET;

		add_item(mk(bss_pkg::ACT_SELECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			'{4'd0, 4'd0, bss_pkg::ST_OK});
		add_item(mk(bss_pkg::ACT_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			'{4'd0, 4'd0, bss_pkg::ST_OK});
		add_item(mk(bss_pkg::ACT_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			'{4'd0, 4'd0, bss_pkg::ST_OK});
		add_item(mk(ACT_SPARE_LO, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1, '0);
		add_item(mk(ACT_SPARE_HI, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1, '0);
		add_item(mk(bss_pkg::ACT_DISABLE, 0, 0, 100, 0, 0, 0, 0, 0), 1'b1, '0);
		add_item(mk(bss_pkg::ACT_SELECT, 50, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			'{4'd0, 4'd0, bss_pkg::ST_NONE});
		add_cfg(bss_pkg::REG_ACTIVE, 32'd16);
		add_cfg(bss_pkg::REG_MODE, 32'(bss_pkg::MODE_LC));
		add_item(mk(bss_pkg::ACT_TIMES, 0, 3, 0, 0, 0, 0, '1, 0), 1'b1, '0);
		add_item(mk(bss_pkg::ACT_DISABLE, '1, 1, '1, 0, 0, 0, 0, 0), 1'b1, '0);
		add_item(mk(bss_pkg::ACT_SELECT, 100, 0, 0, 0, 0, 0, 0, 0));
		add_item(mk(bss_pkg::ACT_FAIL, '1, 15, 0, 0, 0, 0, 0, 0));
		add_cfg(bss_pkg::REG_MODE, 32'(bss_pkg::MODE_RT));
		add_item(mk(bss_pkg::ACT_SELECT, 100, 0, 0, 0, 0, 0, 0, 0));
		add_cfg(bss_pkg::REG_MODE, 32'(bss_pkg::MODE_HS));
		add_item(mk(bss_pkg::ACT_SELECT, 100, 0, 0, 0, 0, '1, 0, 0));
		add_cfg(bss_pkg::REG_MODE, 32'(bss_pkg::MODE_RD));
		add_item(mk(bss_pkg::ACT_SELECT, 100, 0, 0, '1, '1, 0, 0, 0));
		add_cfg(bss_pkg::REG_MODE, 32'(bss_pkg::MODE_MS));
		add_item(mk(bss_pkg::ACT_DISABLE, 10, 0, 5, 0, 0, 0, 0, 0));
		add_item(mk(bss_pkg::ACT_SELECT, 15, 0, 0, 0, 0, 0, 0, 0));
		add_item(mk(bss_pkg::ACT_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
		add_cfg(bss_pkg::REG_MODE, 32'(MODE_BAD_HI));
		add_item(mk(bss_pkg::ACT_SELECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			'{4'd0, 4'd0, bss_pkg::ST_BADMODE});
		add_cfg(bss_pkg::REG_MODE, 32'(MODE_BAD_LO));
		add_cfg(bss_pkg::REG_DEFTIME, '1);
		add_item(mk(bss_pkg::ACT_FAIL, 7, 2, 0, 0, 0, 0, 0, 0));
		add_cfg(bss_pkg::REG_ACTIVE, 32'd31);
		add_cfg(bss_pkg::REG_MODE, 32'(bss_pkg::MODE_RR));
		add_item(mk(bss_pkg::ACT_SELECT, 7, 0, 0, 0, 0, 0, 0, 0));
		add_cfg(bss_pkg::REG_ACTIVE, 32'd0);
		add_item(mk(bss_pkg::ACT_SELECT, 7, 0, 0, 0, 0, 0, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].val);
			else
				send_item(plan[i].item, plan[i].typed, plan[i].res);
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 51; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			if ($urandom_range(9) == 0)
				write_reg(bss_pkg::REG_MODE, $urandom_range(MODE_BAD_HI));
			else
				write_reg(bss_pkg::REG_MODE, 32'(seg % 6));
			write_reg(bss_pkg::REG_ACTIVE, (seg == 3) ? 32'd16 : (seg == 5) ? 32'd1
				: $urandom_range(31));
			write_reg(bss_pkg::REG_DEFTIME, (seg == 6) ? 32'hFFFF_FFFF : $urandom_range(60));
			for (int k = 0; k < per_seg; k++)
				send_item(rand_item(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d transfers in, %0d results out, %0d successful picks,",
			items_sent, results_seen, picks_ok);
		$display("across all six modes, invalid modes and four idle/stall patterns.");
		if (errors == 0 && pending_results.size() == 0)
			$display("backend_server_selector_unit_tb: clean");
		else
			$display("backend_server_selector_unit_tb: errors");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Timeout with %0d results outstanding.", pending_results.size());
		$display("backend_server_selector_unit_tb: errors");
		$finish;
	end

endmodule
